// File: hdl/sgp_pkg.sv
`default_nettype none
package sgp_pkg;

    localparam int IDX_W          = 10;
    localparam int COORD_W        = 32;
    localparam int CNT_W          = 11;
    localparam int CFG_W          = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_ANGLE_BITS = 24;
    localparam int CORDIC_STEPS   = 30;
    localparam int CORDIC_W       = 34;
    localparam logic [31:0] CORDIC_K = 32'h26DD3B6A;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POINT_COUNT = 3'd0,
        REG_RADIUS      = 3'd1,
        REG_CENTER_X    = 3'd2,
        REG_CENTER_Y    = 3'd3,
        REG_CENTER_Z    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
    } point_t;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
        logic                       neg;
    } cordic_t;

    // Arctangent of 2^-k as a 32-bit fraction of a turn.
    function automatic logic [31:0] atan_turn(input int k);
        logic [31:0] v;
        case (k)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: hdl/sgp_div_cell.sv
`default_nettype none
module sgp_div_cell
    import sgp_pkg::*;
#(
    parameter int MW = 10,
    parameter int DW = 34,
    parameter int AB = 24
)
(
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [MW-1:0] m,
    input  wire logic [MW-1:0] rem_in,
    input  wire logic [DW-1:0] dvd_in,
    input  wire logic [AB-1:0] quo_in,
    output logic      [MW-1:0] rem_out,
    output logic      [DW-1:0] dvd_out,
    output logic      [AB-1:0] quo_out
);

    logic [MW:0]   rem_sh;
    logic [MW:0]   diff;
    logic          ge;
    logic [MW-1:0] rem_next;
    logic [DW-1:0] dvd_next;
    logic [AB-1:0] quo_next;
    logic [MW-1:0] rem_reg;
    logic [DW-1:0] dvd_reg;
    logic [AB-1:0] quo_reg;

    // One restoring step: bring down the next dividend bit and try to subtract.
    always_comb
    begin
        rem_sh   = {rem_in, dvd_in[DW-1]};
        diff     = rem_sh - {1'b0, m};
        ge       = (rem_sh >= {1'b0, m});
        rem_next = ge ? diff[MW-1:0] : rem_sh[MW-1:0];
        dvd_next = {dvd_in[DW-2:0], 1'b0};
        quo_next = {quo_in[AB-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
            quo_reg <= quo_next;
        end
    end

    assign rem_out = rem_reg;
    assign dvd_out = dvd_reg;
    assign quo_out = quo_reg;

endmodule
`default_nettype wire

// File: hdl/sgp_cordic_cell.sv
`default_nettype none
module sgp_cordic_cell
    import sgp_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  wire logic    clk,
    input  wire logic    en,
    input  wire cordic_t d_in,
    output cordic_t      d_out
);

    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [CORDIC_W-1:0] at;
    cordic_t                    d_next;
    cordic_t                    d_reg;

    always_comb
    begin
        xs         = d_in.x >>> STAGE;
        ys         = d_in.y >>> STAGE;
        at         = $signed({2'b00, atan_turn(STAGE)});
        d_next.neg = d_in.neg;
        if (!d_in.z[CORDIC_W-1])
        begin
            d_next.x = d_in.x - ys;
            d_next.y = d_in.y + xs;
            d_next.z = d_in.z - at;
        end
        else
        begin
            d_next.x = d_in.x + ys;
            d_next.y = d_in.y - xs;
            d_next.z = d_in.z + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule
`default_nettype wire

// File: hdl/sphere_grid_point.sv
// sphere_grid_point: one point of a UV sphere per request.
// A request on the item channel carries a grid index pair (row_index,
// col_index); the point channel returns the x, y and z coordinates in
// signed Q16.16, saturated. Both channels use valid and stall; a request
// moves when valid is high and stall is low.
// The pipeline is a dividend register, the bit-per-cell divider chain
// (ANGLE_BITS + 10 cells) that forms both angles, a CORDIC start
// register, the 30-cell CORDIC chain and four multiply/output stages.
// Throughput is one point per cycle; a new request is taken every cycle
// while no offered point is stalled.
// The whole pipeline advances together: while an offered point is stalled,
// every stage holds and item_stall is raised.
// Reset empties the pipeline and loads point_count 50, radius 1.0 and a
// zero center. Writes go through cfg_we, cfg_index and cfg_data; the user
// must write only while no request is in flight: the block does not check.
`default_nettype none
module sphere_grid_point
    import sgp_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int ANGLE_BITS = DEF_ANGLE_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire item_t                item,
    output logic                      point_valid,
    input  wire logic                 point_stall,
    output point_t                    point,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int MW     = $clog2(MAX_POINTS);
    localparam int DW     = IDX_W + ANGLE_BITS;
    localparam int NSTAGE = DW + CORDIC_STEPS + 6;

    logic [CNT_W-1:0]          point_count_reg;
    logic [31:0]               radius_reg;
    logic signed [COORD_W-1:0] center_x_reg;
    logic signed [COORD_W-1:0] center_y_reg;
    logic signed [COORD_W-1:0] center_z_reg;

    logic [31:0]   n_w;
    logic [31:0]   m_w;
    logic [MW-1:0] m;
    logic          en;
    logic [NSTAGE-1:0] vld_reg;

    logic [DW-1:0] th_dvd_next;
    logic [DW-1:0] ph_dvd_next;
    logic [DW-1:0] th_dvd_reg;
    logic [DW-1:0] ph_dvd_reg;

    logic [MW-1:0]         th_rem [DW+1];
    logic [DW-1:0]         th_dvd [DW+1];
    logic [ANGLE_BITS-1:0] th_quo [DW+1];
    logic [MW-1:0]         ph_rem [DW+1];
    logic [DW-1:0]         ph_dvd [DW+1];
    logic [ANGLE_BITS-1:0] ph_quo [DW+1];

    logic [ANGLE_BITS-1:0] th_ang;
    cordic_t               th_init_reg;
    cordic_t               ph_init_reg;
    cordic_t               th_cor [CORDIC_STEPS+1];
    cordic_t               ph_cor [CORDIC_STEPS+1];

    logic signed [31:0] ct_reg;
    logic signed [31:0] st_reg;
    logic signed [31:0] cp_reg;
    logic signed [31:0] sp_reg;
    logic signed [63:0] p_cc;
    logic signed [63:0] p_cs;
    logic signed [63:0] r_cc;
    logic signed [63:0] r_cs;
    logic signed [31:0] cc_reg;
    logic signed [31:0] cs_reg;
    logic signed [31:0] st1_reg;
    logic signed [32:0] rad_s;
    logic signed [64:0] px_reg;
    logic signed [64:0] py_reg;
    logic signed [64:0] pz_reg;
    point_t             point_reg;

    function automatic cordic_t cordic_init(input logic [ANGLE_BITS-1:0] ang);
        logic [31:0] a;
        logic        ng;
        cordic_t     c;
        a     = 32'(ang) << (32 - ANGLE_BITS);
        // Quadrants two and three are folded by a half turn and negated later.
        ng    = a[31] ^ a[30];
        a[31] = a[31] ^ ng;
        c.x   = CORDIC_W'($signed({1'b0, CORDIC_K}));
        c.y   = '0;
        c.z   = CORDIC_W'($signed(a));
        c.neg = ng;
        return c;
    endfunction

    function automatic logic signed [31:0] trig_out(input cordic_t c, input logic use_y);
        logic signed [CORDIC_W-1:0] v;
        v = use_y ? c.y : c.x;
        if (c.neg)
        begin
            v = -v;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [64:0]        p,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [64:0]        r;
        logic signed [35:0]        v;
        logic signed [COORD_W-1:0] o;
        r = (p + 65'sd536870912) >>> 30;
        v = $signed(r[35:0]) + 36'(c);
        if (v > 36'sd2147483647)
        begin
            o = 32'sh7FFFFFFF;
        end
        else if (v < -36'sd2147483648)
        begin
            o = 32'sh80000000;
        end
        else
        begin
            o = v[31:0];
        end
        return o;
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= CNT_W'(50);
            radius_reg      <= 32'd65536;
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            center_z_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_POINT_COUNT: point_count_reg <= cfg_data[CNT_W-1:0];
                REG_RADIUS:      radius_reg      <= cfg_data;
                REG_CENTER_X:    center_x_reg    <= $signed(cfg_data);
                REG_CENTER_Y:    center_y_reg    <= $signed(cfg_data);
                REG_CENTER_Z:    center_z_reg    <= $signed(cfg_data);
                default:         ;
            endcase
        end
    end

    // Divisor m = clamp(point_count, 2, MAX_POINTS) - 1.
    always_comb
    begin
        n_w = 32'(point_count_reg);
        if (n_w < 32'd2)
        begin
            n_w = 32'd2;
        end
        if (n_w > 32'(MAX_POINTS))
        begin
            n_w = 32'(MAX_POINTS);
        end
        m_w = n_w - 32'd1;
    end
    assign m = m_w[MW-1:0];

    assign en          = !(vld_reg[NSTAGE-1] && point_stall);
    assign item_stall  = !en;
    assign point_valid = vld_reg[NSTAGE-1];
    assign point       = point_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], item_valid};
        end
    end

    // Dividends with the rounding half divisor already added.
    assign th_dvd_next = {item.row_index, {ANGLE_BITS{1'b0}}} + DW'(m >> 1);
    assign ph_dvd_next = DW'({item.col_index, {(ANGLE_BITS-1){1'b0}}}) + DW'(m >> 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th_dvd_reg <= th_dvd_next;
            ph_dvd_reg <= ph_dvd_next;
        end
    end

    assign th_rem[0] = '0;
    assign th_dvd[0] = th_dvd_reg;
    assign th_quo[0] = '0;
    assign ph_rem[0] = '0;
    assign ph_dvd[0] = ph_dvd_reg;
    assign ph_quo[0] = '0;

    for (genvar k = 0; k < DW; k++)
    begin : g_div
        sgp_div_cell #(.MW(MW), .DW(DW), .AB(ANGLE_BITS)) u_th_div
        (
            .clk     (clk),
            .en      (en),
            .m       (m),
            .rem_in  (th_rem[k]),
            .dvd_in  (th_dvd[k]),
            .quo_in  (th_quo[k]),
            .rem_out (th_rem[k+1]),
            .dvd_out (th_dvd[k+1]),
            .quo_out (th_quo[k+1])
        );
        sgp_div_cell #(.MW(MW), .DW(DW), .AB(ANGLE_BITS)) u_ph_div
        (
            .clk     (clk),
            .en      (en),
            .m       (m),
            .rem_in  (ph_rem[k]),
            .dvd_in  (ph_dvd[k]),
            .quo_in  (ph_quo[k]),
            .rem_out (ph_rem[k+1]),
            .dvd_out (ph_dvd[k+1]),
            .quo_out (ph_quo[k+1])
        );
    end

    // Theta starts at a quarter turn and steps down.
    assign th_ang = ANGLE_BITS'(1 << (ANGLE_BITS - 2)) - th_quo[DW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th_init_reg <= cordic_init(th_ang);
            ph_init_reg <= cordic_init(ph_quo[DW]);
        end
    end

    assign th_cor[0] = th_init_reg;
    assign ph_cor[0] = ph_init_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        sgp_cordic_cell #(.STAGE(k)) u_th_cell
        (
            .clk   (clk),
            .en    (en),
            .d_in  (th_cor[k]),
            .d_out (th_cor[k+1])
        );
        sgp_cordic_cell #(.STAGE(k)) u_ph_cell
        (
            .clk   (clk),
            .en    (en),
            .d_in  (ph_cor[k]),
            .d_out (ph_cor[k+1])
        );
    end

    assign p_cc  = ct_reg * cp_reg;
    assign p_cs  = ct_reg * sp_reg;
    assign r_cc  = (p_cc + 64'sd536870912) >>> 30;
    assign r_cs  = (p_cs + 64'sd536870912) >>> 30;
    assign rad_s = $signed({1'b0, radius_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ct_reg  <= trig_out(th_cor[CORDIC_STEPS], 1'b0);
            st_reg  <= trig_out(th_cor[CORDIC_STEPS], 1'b1);
            cp_reg  <= trig_out(ph_cor[CORDIC_STEPS], 1'b0);
            sp_reg  <= trig_out(ph_cor[CORDIC_STEPS], 1'b1);
            cc_reg  <= r_cc[31:0];
            cs_reg  <= r_cs[31:0];
            st1_reg <= st_reg;
            px_reg  <= rad_s * cc_reg;
            py_reg  <= rad_s * cs_reg;
            pz_reg  <= rad_s * st1_reg;
            point_reg.x_coord <= sat_coord(px_reg, center_x_reg);
            point_reg.y_coord <= sat_coord(py_reg, center_y_reg);
            point_reg.z_coord <= sat_coord(pz_reg, center_z_reg);
        end
    end

`ifndef SYNTHESIS
    a_m_nonzero: assert property (@(posedge clk) disable iff (!rst_n) m != '0)
        else $error("divisor is zero");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DW] |-> (th_rem[DW] < m) && (ph_rem[DW] < m))
        else $error("divider remainder out of range");
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> vld_reg[0])
        else $error("accepted request not tracked");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while held");
`endif

endmodule
`default_nettype wire
